// File: rtl/mdts_pkg.sv
// ----------------------------------------------------------------------------
// mdts_pkg
// Shared types and constants for the multiple deadline timeout set.
// ----------------------------------------------------------------------------
package mdts_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int TIME_BITS = 48;

   localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   // The sum of a time and a timeout needs one bit above the wider of the two.
   localparam int SUM_BITS  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
   localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ARM  = 1'b1;

   typedef struct packed {
      logic        op;
      logic [47:0] now_us;
      logic [31:0] timeout_us;
   } req_type;

   typedef struct packed {
      logic       timeout_event;
      logic       arm_rejected;
      logic [4:0] pending_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic arm_write;
      logic scan_read;
      logic apply;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op;
      logic scan_last;
      logic rsp_busy;
   } status_type;

endpackage

// File: rtl/mdts_ram.sv
// ----------------------------------------------------------------------------
// mdts_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mdts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mdts_ctrl.sv
// ----------------------------------------------------------------------------
// mdts_ctrl
// Sequencer that steps each request through its phases: a write for an arm, scan and apply for a tick.
// ----------------------------------------------------------------------------
module mdts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mdts_pkg::status_type status,
   output mdts_pkg::cmd_type    cmd
);
   import mdts_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ARM    = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_APPLY  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_ARM;
            end
         end
         ST_ARM: begin
            // The request op is known only once it has been captured.
            if (status.op == OP_ARM) begin
               cmd.arm_write = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/mdts_datapath.sv
// ----------------------------------------------------------------------------
// mdts_datapath
// Deadline store, slot valid bits, minimum search and response register.
// ----------------------------------------------------------------------------
module mdts_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  mdts_pkg::req_type    req_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output mdts_pkg::rsp_type    rsp_data,
   input  mdts_pkg::cmd_type    cmd,
   output mdts_pkg::status_type status
);
   import mdts_pkg::*;

   // Captured request.
   logic                 op_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [31:0]          timeout_ff;

   logic [NUM_SLOTS-1:0] slot_valid_ff, slot_valid_in;

   // Scan state.
   logic [SLOT_BITS-1:0] idx_ff;
   logic                 cmp_vld_ff;
   logic [SLOT_BITS-1:0] cmp_idx_ff;
   logic                 any_ff;
   logic [TIME_BITS-1:0] min_ff;
   logic [NUM_SLOTS-1:0] match_ff;

   logic                 event_ff;
   logic                 rejected_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic [SUM_BITS-1:0]  sum;
   logic [TIME_BITS-1:0] deadline;
   logic [SLOT_BITS-1:0] free_idx;
   logic                 full;
   logic [TIME_BITS-1:0] rd_data;
   logic [NUM_SLOTS-1:0] cmp_onehot;
   logic                 expired;
   logic [8:0]           count;

   // Saturating deadline.
   always_comb begin
      sum      = SUM_BITS'(now_ff) + SUM_BITS'(timeout_ff);
      deadline = (|(sum >> TIME_BITS)) ? '1 : sum[TIME_BITS-1:0];
   end

   // Lowest free slot.
   always_comb begin
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = SLOT_BITS'(i);
         end
      end
   end

   assign full       = &slot_valid_ff;
   assign cmp_onehot = NUM_SLOTS'(1) << cmp_idx_ff;
   assign expired    = any_ff && (min_ff <= now_ff);

   mdts_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (NUM_SLOTS)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (cmd.arm_write && !full),
      .wr_addr (free_idx),
      .wr_data (deadline),
      .rd_en   (cmd.scan_read),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (cmd.arm_write && !full) begin
         slot_valid_in[free_idx] = 1'b1;
      end else if (cmd.apply && expired) begin
         slot_valid_in = slot_valid_ff & ~match_ff;
      end
   end

   always_comb begin
      count = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         count = count + 9'(slot_valid_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         cmp_vld_ff    <= cmd.scan_read;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff       <= req_data.op;
         now_ff      <= TIME_BITS'(req_data.now_us);
         timeout_ff  <= req_data.timeout_us;
         idx_ff      <= '0;
         any_ff      <= 1'b0;
         match_ff    <= '0;
         event_ff    <= 1'b0;
         rejected_ff <= 1'b0;
      end else begin
         if (cmd.scan_read) begin
            idx_ff <= idx_ff + SLOT_BITS'(1);
         end
         if (cmp_vld_ff && slot_valid_ff[cmp_idx_ff]) begin
            if (!any_ff || (rd_data < min_ff)) begin
               any_ff   <= 1'b1;
               min_ff   <= rd_data;
               match_ff <= cmp_onehot;
            end else if (rd_data == min_ff) begin
               match_ff <= match_ff | cmp_onehot;
            end
         end
         if (cmd.arm_write) begin
            rejected_ff <= full;
         end
         if (cmd.apply) begin
            event_ff <= expired;
         end
      end
      cmp_idx_ff <= idx_ff;
      if (cmd.rsp_load) begin
         rsp_data_ff.timeout_event <= event_ff;
         rsp_data_ff.arm_rejected  <= rejected_ff;
         rsp_data_ff.pending_count <= count[4:0];
      end
   end

   assign status.op        = op_ff;
   assign status.scan_last = (idx_ff == SLOT_BITS'(NUM_SLOTS - 1));
   assign status.rsp_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/multi_deadline_timeout_set_core.sv
// Flow: an accepted arm beat passes through the ARM and FINISH states, a tick beat through
// ARM, SCAN (one deadline store read per slot), DRAIN, APPLY and FINISH, where it waits
// while the previous response is still stalled. A new beat is taken only back in IDLE; the
// slot scan through the single read port of the deadline store sets the tick rate.
// Reset (synchronous, active high) frees every slot and drops any waiting response.
// ----------------------------------------------------------------------------
// multi_deadline_timeout_set_core
// Table of pending absolute deadlines with arm and tick requests.
// ----------------------------------------------------------------------------
module multi_deadline_timeout_set_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mdts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mdts_pkg::rsp_type rsp_data
);
   import mdts_pkg::*;

   // The controller walks each accepted beat through its phases. An arm beat
   // writes its saturated deadline into the lowest free slot, or is flagged as
   // rejected when every slot is taken. A tick beat reads the deadline store
   // once from the first slot to the last, keeping the earliest valid deadline
   // and a mask of every slot that holds exactly that value; if that earliest
   // deadline is at or before the tick time, the masked slots are freed and a
   // timeout event is reported.
   cmd_type    cmd;
   status_type status;

   mdts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The response register sits in the datapath, so a new beat can be taken
   // while the previous response still waits on a stalled result channel.
   mdts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: rtl/mdts_checker.sv
// ----------------------------------------------------------------------------
// mdts_checker
// Port level checks on the deadline timeout set, bound to the top level.
// ----------------------------------------------------------------------------
module mdts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mdts_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mdts_pkg::rsp_type rsp_data
);
   import mdts_pkg::*;

   // A response waiting on a stalled channel keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // A beat is either a tick or an arm, so both flags never show together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.timeout_event && rsp_data.arm_rejected))
      else $error("event and rejection in one response");

   // A rejected arm means the table was full and stays full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.arm_rejected |->
         rsp_data.pending_count == 5'(NUM_SLOTS))
      else $error("arm rejected while slots are free");

   // No response survives reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind multi_deadline_timeout_set_core mdts_checker u_mdts_checker (.*);
